@@ design/prnb_pkg.sv @@
// Shared codes and types for the postfix regular-expression NFA builder.
`timescale 1ns / 1ps

package prnb_pkg;

	localparam logic [1:0] MODE_PUSH  = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	localparam logic [7:0] TOK_STAR = 8'h2A;
	localparam logic [7:0] TOK_DOT  = 8'h2E;
	localparam logic [7:0] TOK_BAR  = 8'h7C;

	typedef enum logic [2:0] {
		STAT_OK         = 3'd0,
		STAT_UNDERFLOW  = 3'd1,
		STAT_STACK_FULL = 3'd2,
		STAT_TABLE_FULL = 3'd3,
		STAT_DROPPED    = 3'd4,
		STAT_BAD_INDEX  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LIT,
		OP_STAR,
		OP_CAT,
		OP_ALT,
		OP_READ
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_P4,
		ST_FIN
	} state_t;

endpackage

@@ design/postfix_regex_nfa_builder.sv @@
// Top level of the postfix regular-expression to NFA builder (Thompson construction).
`timescale 1ns / 1ps

// Postfix tokens are taken one request at a time and turned into an NFA held in a
// single-write-port node table, with a fragment stack in a second memory; both memories
// have a registered read port. One request occupies the block from acceptance until its
// result is loaded: a clear, unused mode or rejected token goes straight to ST_FIN,
// a literal or a node read passes ST_P1 and ST_P2, '*' and '.' pass ST_P3 too, and '|'
// passes ST_P4 as well. This comes from the node table's single write port (one node
// entry written per cycle) and from the read-modify-write of existing nodes, which waits
// for read data, and for '.' and '|' also for the lower fragment from the stack memory.
// The table is tracked by a fill count, so no clearing pass runs after reset or clear. A
// result waiting on out_stall holds the block in ST_FIN; the next request comes after.
module postfix_regex_nfa_builder
	import prnb_pkg::*;
#(
	parameter int MAX_NODES   = 256,
	parameter int STACK_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] mode,
	input  logic [7:0] token,
	input  logic [7:0] node_index,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status,
	output logic [7:0] frag_start,
	output logic [7:0] frag_end,
	output logic [6:0] stack_level,
	output logic [7:0] node_symbol,
	output logic       sym_link_valid,
	output logic [7:0] sym_link,
	output logic       eps_a_valid,
	output logic [7:0] eps_a,
	output logic       eps_b_valid,
	output logic [7:0] eps_b,
	output logic       node_accepting
);

	localparam int NW  = $clog2(MAX_NODES);
	localparam int NUW = NW + 1;
	localparam int SW  = $clog2(STACK_DEPTH);
	localparam int TW  = SW + 1;
	localparam int IDW = (NW > 8) ? NW : 8;
	localparam int CW  = (NUW > 8) ? NUW : 8;
	localparam int LVW = (TW > 7) ? TW : 7;

	typedef struct packed {
		logic          accepting;
		logic [7:0]    symbol;
		logic          sym_valid;
		logic [NW-1:0] sym_to;
		logic          ea_valid;
		logic [NW-1:0] ea_to;
		logic          eb_valid;
		logic [NW-1:0] eb_to;
	} node_t;

	typedef struct packed {
		logic [NW-1:0] start_node;
		logic [NW-1:0] end_node;
	} frag_t;

	function automatic logic [7:0] low8(input logic [NW-1:0] v);
		logic [IDW-1:0] w;
		w = IDW'(v);
		return w[7:0];
	endfunction

	// Memories.
	node_t node_mem [MAX_NODES];
	frag_t stk_mem [STACK_DEPTH];

	node_t         node_rdata;
	logic          node_re;
	logic [NW-1:0] node_raddr;
	logic          node_we;
	logic [NW-1:0] node_waddr;
	node_t         node_wdata;

	frag_t         stk_rdata;
	logic          stk_re;
	logic [SW-1:0] stk_raddr;
	logic          stk_we;
	logic [SW-1:0] stk_waddr;
	frag_t         stk_wdata;

	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[node_waddr] <= node_wdata;
		end
		if (node_re) begin
			node_rdata <= node_mem[node_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		if (stk_re) begin
			stk_rdata <= stk_mem[stk_raddr];
		end
	end

	// Control and state registers.
	state_t        state_q;
	state_t        state_d;
	op_t           op_q;
	status_t       status_q;
	logic          dropped_q;
	logic [NUW-1:0] nu_q;
	logic [TW-1:0] top_q;
	frag_t         tos_q;
	logic [7:0]    tok_q;
	logic [NW-1:0] idx_q;

	logic          accept;
	op_t           acc_op;
	status_t       acc_status;

	logic          nodes_add;
	logic          top_inc;
	logic          top_dec;
	logic          tos_we;
	frag_t         tos_new;
	logic          rmw;
	logic          out_load;

	// Link insertion for read-modify-write of existing nodes.
	logic          ins_add1;
	logic [NW-1:0] ins_to1;
	logic          ins_add2;
	logic [NW-1:0] ins_to2;
	logic          ins_ea_valid;
	logic [NW-1:0] ins_ea_to;
	logic          ins_eb_valid;
	logic [NW-1:0] ins_eb_to;
	logic          ins_dropped;
	node_t         rmw_data;

	prnb_link_insert #(
		.NW(NW)
	) u_link_insert (
		.ea_valid    (node_rdata.ea_valid),
		.ea_to       (node_rdata.ea_to),
		.eb_valid    (node_rdata.eb_valid),
		.eb_to       (node_rdata.eb_to),
		.add_first   (ins_add1),
		.first_to    (ins_to1),
		.add_second  (ins_add2),
		.second_to   (ins_to2),
		.new_ea_valid(ins_ea_valid),
		.new_ea_to   (ins_ea_to),
		.new_eb_valid(ins_eb_valid),
		.new_eb_to   (ins_eb_to),
		.dropped     (ins_dropped)
	);

	always_comb begin
		rmw_data           = node_rdata;
		rmw_data.accepting = 1'b0;
		rmw_data.ea_valid  = ins_ea_valid;
		rmw_data.ea_to     = ins_ea_to;
		rmw_data.eb_valid  = ins_eb_valid;
		rmw_data.eb_to     = ins_eb_to;
	end

	// Request decode and checks, evaluated while idle.
	logic           is_star;
	logic           is_bin;
	logic           is_lit;
	logic           underflow;
	logic           stack_full;
	logic           table_full;
	logic           bad_index;
	logic [CW-1:0]  idx_ext;

	assign is_star    = (token == TOK_STAR);
	assign is_bin     = (token == TOK_DOT) || (token == TOK_BAR);
	assign is_lit     = !is_star && !is_bin;
	assign underflow  = is_bin ? (top_q < TW'(2)) : (is_star && (top_q == '0));
	assign stack_full = is_lit && (top_q == TW'(STACK_DEPTH));
	assign table_full = (token != TOK_DOT) &&
		(({1'b0, nu_q} + (NUW + 1)'(2)) > (NUW + 1)'(MAX_NODES));
	assign idx_ext    = CW'(node_index);
	assign bad_index  = idx_ext >= CW'(nu_q);

	always_comb begin
		acc_op     = OP_NONE;
		acc_status = STAT_OK;
		unique case (mode)
			MODE_PUSH: begin
				priority if (underflow) begin
					acc_status = STAT_UNDERFLOW;
				end else if (stack_full) begin
					acc_status = STAT_STACK_FULL;
				end else if (table_full) begin
					acc_status = STAT_TABLE_FULL;
				end else if (is_star) begin
					acc_op = OP_STAR;
				end else if (token == TOK_DOT) begin
					acc_op = OP_CAT;
				end else if (token == TOK_BAR) begin
					acc_op = OP_ALT;
				end else begin
					acc_op = OP_LIT;
				end
			end
			MODE_READ: begin
				if (bad_index) begin
					acc_status = STAT_BAD_INDEX;
				end else begin
					acc_op = OP_READ;
				end
			end
			MODE_CLEAR, MODE_NONE: begin
				acc_op = OP_NONE;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);

	// Sequencer: next state and memory operations.
	logic [NW-1:0] nu0;
	logic [NW-1:0] nu1;
	logic [TW-1:0] top_m1;
	logic [TW-1:0] top_m2;
	frag_t         hi;
	frag_t         lo;
	frag_t         fresh_pair;

	assign nu0        = nu_q[NW-1:0];
	assign nu1        = nu0 + NW'(1);
	assign top_m1     = top_q - TW'(1);
	assign top_m2     = top_q - TW'(2);
	assign hi         = tos_q;
	assign lo         = stk_rdata;
	assign fresh_pair = '{start_node: nu0, end_node: nu1};

	always_comb begin
		state_d    = state_q;
		node_re    = 1'b0;
		node_raddr = '0;
		node_we    = 1'b0;
		node_waddr = '0;
		node_wdata = '0;
		stk_re     = 1'b0;
		stk_raddr  = '0;
		stk_we     = 1'b0;
		stk_waddr  = '0;
		stk_wdata  = '0;
		nodes_add  = 1'b0;
		top_inc    = 1'b0;
		top_dec    = 1'b0;
		tos_we     = 1'b0;
		tos_new    = '0;
		rmw        = 1'b0;
		ins_add1   = 1'b0;
		ins_to1    = '0;
		ins_add2   = 1'b0;
		ins_to2    = '0;
		out_load   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (acc_op == OP_NONE) ? ST_FIN : ST_P1;
				end
			end
			ST_P1: begin
				state_d = ST_P2;
				unique case (op_q)
					OP_LIT: begin
						node_we              = 1'b1;
						node_waddr           = nu0;
						node_wdata.sym_valid = 1'b1;
						node_wdata.sym_to    = nu1;
						stk_we               = 1'b1;
						stk_waddr            = top_q[SW-1:0];
						stk_wdata            = fresh_pair;
					end
					OP_STAR: begin
						node_re             = 1'b1;
						node_raddr          = hi.end_node;
						node_we             = 1'b1;
						node_waddr          = nu0;
						node_wdata.ea_valid = 1'b1;
						node_wdata.ea_to    = hi.start_node;
						node_wdata.eb_valid = 1'b1;
						node_wdata.eb_to    = nu1;
					end
					OP_ALT: begin
						stk_re               = 1'b1;
						stk_raddr            = top_m2[SW-1:0];
						node_we              = 1'b1;
						node_waddr           = nu1;
						node_wdata.accepting = 1'b1;
					end
					OP_CAT: begin
						stk_re    = 1'b1;
						stk_raddr = top_m2[SW-1:0];
					end
					OP_READ: begin
						node_re    = 1'b1;
						node_raddr = idx_q;
					end
					OP_NONE: begin
						state_d = ST_FIN;
					end
					default: begin
						state_d = ST_FIN;
					end
				endcase
			end
			ST_P2: begin
				state_d = ST_P3;
				unique case (op_q)
					OP_LIT: begin
						node_we              = 1'b1;
						node_waddr           = nu1;
						node_wdata.accepting = 1'b1;
						node_wdata.symbol    = tok_q;
						nodes_add            = 1'b1;
						top_inc              = 1'b1;
						tos_we               = 1'b1;
						tos_new              = fresh_pair;
						state_d              = ST_FIN;
					end
					OP_STAR: begin
						// Old end links to the new end and back to its own start.
						rmw        = 1'b1;
						ins_add1   = 1'b1;
						ins_to1    = nu1;
						ins_add2   = 1'b1;
						ins_to2    = hi.start_node;
						node_we    = 1'b1;
						node_waddr = hi.end_node;
						node_wdata = rmw_data;
					end
					OP_ALT: begin
						node_re             = 1'b1;
						node_raddr          = lo.end_node;
						node_we             = 1'b1;
						node_waddr          = nu0;
						node_wdata.ea_valid = 1'b1;
						node_wdata.ea_to    = lo.start_node;
						node_wdata.eb_valid = 1'b1;
						node_wdata.eb_to    = hi.start_node;
					end
					OP_CAT: begin
						node_re    = 1'b1;
						node_raddr = lo.end_node;
					end
					default: begin
						state_d = ST_FIN;
					end
				endcase
			end
			ST_P3: begin
				state_d = ST_FIN;
				unique case (op_q)
					OP_STAR: begin
						node_we              = 1'b1;
						node_waddr           = nu1;
						node_wdata.accepting = 1'b1;
						stk_we               = 1'b1;
						stk_waddr            = top_m1[SW-1:0];
						stk_wdata            = fresh_pair;
						tos_we               = 1'b1;
						tos_new              = fresh_pair;
						nodes_add            = 1'b1;
					end
					OP_ALT: begin
						// Lower end is rewritten while the upper end is fetched.
						rmw        = 1'b1;
						ins_add1   = 1'b1;
						ins_to1    = nu1;
						node_we    = 1'b1;
						node_waddr = lo.end_node;
						node_wdata = rmw_data;
						node_re    = 1'b1;
						node_raddr = hi.end_node;
						state_d    = ST_P4;
					end
					OP_CAT: begin
						rmw                = 1'b1;
						ins_add1           = 1'b1;
						ins_to1            = hi.start_node;
						node_we            = 1'b1;
						node_waddr         = lo.end_node;
						node_wdata         = rmw_data;
						stk_we             = 1'b1;
						stk_waddr          = top_m2[SW-1:0];
						stk_wdata          = '{start_node: lo.start_node,
							end_node: hi.end_node};
						tos_we             = 1'b1;
						tos_new            = stk_wdata;
						top_dec            = 1'b1;
					end
					default: begin
						state_d = ST_FIN;
					end
				endcase
			end
			ST_P4: begin
				state_d    = ST_FIN;
				rmw        = 1'b1;
				ins_add1   = 1'b1;
				ins_to1    = nu1;
				node_we    = 1'b1;
				node_waddr = hi.end_node;
				node_wdata = rmw_data;
				stk_we     = 1'b1;
				stk_waddr  = top_m2[SW-1:0];
				stk_wdata  = fresh_pair;
				tos_we     = 1'b1;
				tos_new    = fresh_pair;
				top_dec    = 1'b1;
				nodes_add  = 1'b1;
			end
			ST_FIN: begin
				if (!out_valid || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= OP_NONE;
			status_q  <= STAT_OK;
			dropped_q <= 1'b0;
			nu_q      <= '0;
			top_q     <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q      <= acc_op;
				status_q  <= acc_status;
				dropped_q <= 1'b0;
				if (mode == MODE_CLEAR) begin
					nu_q  <= '0;
					top_q <= '0;
				end
			end else begin
				if (rmw && ins_dropped) begin
					dropped_q <= 1'b1;
				end
				if (nodes_add) begin
					nu_q <= nu_q + NUW'(2);
				end
				if (top_inc) begin
					top_q <= top_q + TW'(1);
				end else if (top_dec) begin
					top_q <= top_m1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tok_q <= token;
			idx_q <= idx_ext[NW-1:0];
		end
		if (tos_we) begin
			tos_q <= tos_new;
		end
	end

	// Result register.
	logic          out_valid_q;
	status_t       res_status_q;
	logic [7:0]    res_frag_start_q;
	logic [7:0]    res_frag_end_q;
	logic [6:0]    res_level_q;
	logic [7:0]    res_symbol_q;
	logic          res_sym_valid_q;
	logic [7:0]    res_sym_link_q;
	logic          res_ea_valid_q;
	logic [7:0]    res_ea_q;
	logic          res_eb_valid_q;
	logic [7:0]    res_eb_q;
	logic          res_accepting_q;
	logic [LVW-1:0] level_ext;
	logic          rd_ok;

	assign level_ext = LVW'(top_q);
	assign rd_ok     = (op_q == OP_READ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_status_q     <= dropped_q ? STAT_DROPPED : status_q;
			res_frag_start_q <= (top_q == '0) ? 8'd0 : low8(tos_q.start_node);
			res_frag_end_q   <= (top_q == '0) ? 8'd0 : low8(tos_q.end_node);
			res_level_q      <= level_ext[6:0];
			res_symbol_q     <= rd_ok ? node_rdata.symbol : 8'd0;
			res_sym_valid_q  <= rd_ok && node_rdata.sym_valid;
			res_sym_link_q   <= (rd_ok && node_rdata.sym_valid) ?
				low8(node_rdata.sym_to) : 8'd0;
			res_ea_valid_q   <= rd_ok && node_rdata.ea_valid;
			res_ea_q         <= (rd_ok && node_rdata.ea_valid) ?
				low8(node_rdata.ea_to) : 8'd0;
			res_eb_valid_q   <= rd_ok && node_rdata.eb_valid;
			res_eb_q         <= (rd_ok && node_rdata.eb_valid) ?
				low8(node_rdata.eb_to) : 8'd0;
			res_accepting_q  <= rd_ok && node_rdata.accepting;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = res_status_q;
	assign frag_start     = res_frag_start_q;
	assign frag_end       = res_frag_end_q;
	assign stack_level    = res_level_q;
	assign node_symbol    = res_symbol_q;
	assign sym_link_valid = res_sym_valid_q;
	assign sym_link       = res_sym_link_q;
	assign eps_a_valid    = res_ea_valid_q;
	assign eps_a          = res_ea_q;
	assign eps_b_valid    = res_eb_valid_q;
	assign eps_b          = res_eb_q;
	assign node_accepting = res_accepting_q;

endmodule

@@ design/prnb_link_insert.sv @@
// Epsilon-link insertion for one node; a link that finds no free slot is flagged.
`timescale 1ns / 1ps

module prnb_link_insert #(
	parameter int NW = 8
) (
	input  logic          ea_valid,
	input  logic [NW-1:0] ea_to,
	input  logic          eb_valid,
	input  logic [NW-1:0] eb_to,
	input  logic          add_first,
	input  logic [NW-1:0] first_to,
	input  logic          add_second,
	input  logic [NW-1:0] second_to,
	output logic          new_ea_valid,
	output logic [NW-1:0] new_ea_to,
	output logic          new_eb_valid,
	output logic [NW-1:0] new_eb_to,
	output logic          dropped
);

	logic          a_v;
	logic [NW-1:0] a_t;
	logic          b_v;
	logic [NW-1:0] b_t;
	logic          drop;

	always_comb begin
		a_v  = ea_valid;
		a_t  = ea_to;
		b_v  = eb_valid;
		b_t  = eb_to;
		drop = 1'b0;
		// The first link is placed before the second one looks for a slot.
		if (add_first) begin
			priority if (!a_v) begin
				a_v = 1'b1;
				a_t = first_to;
			end else if (!b_v) begin
				b_v = 1'b1;
				b_t = first_to;
			end else begin
				drop = 1'b1;
			end
		end
		if (add_second) begin
			priority if (!a_v) begin
				a_v = 1'b1;
				a_t = second_to;
			end else if (!b_v) begin
				b_v = 1'b1;
				b_t = second_to;
			end else begin
				drop = 1'b1;
			end
		end
	end

	assign new_ea_valid = a_v;
	assign new_ea_to    = a_t;
	assign new_eb_valid = b_v;
	assign new_eb_to    = b_t;
	assign dropped      = drop;

endmodule

@@ tb/postfix_regex_nfa_checker.sv @@
// Request and result monitor with a node-table predictor for the postfix NFA builder.
`timescale 1ns / 1ps

module postfix_regex_nfa_checker
	import prnb_pkg::*;
#(
	parameter int MAX_NODES   = 256,
	parameter int STACK_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] mode,
	input  logic [7:0] token,
	input  logic [7:0] node_index,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [2:0] status,
	input  logic [7:0] frag_start,
	input  logic [7:0] frag_end,
	input  logic [6:0] stack_level,
	input  logic [7:0] node_symbol,
	input  logic       sym_link_valid,
	input  logic [7:0] sym_link,
	input  logic       eps_a_valid,
	input  logic [7:0] eps_a,
	input  logic       eps_b_valid,
	input  logic [7:0] eps_b,
	input  logic       node_accepting,
	output int         errors,
	output int         pending,
	output int         compared
);

	typedef struct packed {
		status_t    code;
		logic [7:0] top_start;
		logic [7:0] top_end;
		logic [6:0] level;
		logic [7:0] symbol;
		logic       sym_v;
		logic [7:0] sym_to;
		logic       epa_v;
		logic [7:0] epa_to;
		logic       epb_v;
		logic [7:0] epb_to;
		logic       final_mark;
	} nfa_result_t;

	// Node table of the NFA under construction.
	bit         n_final  [MAX_NODES];
	bit   [7:0] n_symbol [MAX_NODES];
	bit         n_sym_v  [MAX_NODES];
	int         n_sym_to [MAX_NODES];
	bit         n_epa_v  [MAX_NODES];
	int         n_epa_to [MAX_NODES];
	bit         n_epb_v  [MAX_NODES];
	int         n_epb_to [MAX_NODES];
	int         node_count;

	// Fragment stack of (start, end) node pairs.
	int stk_start [STACK_DEPTH];
	int stk_end   [STACK_DEPTH];
	int depth;

	bit lost_link;
	nfa_result_t due_results[$];

	function automatic op_t token_op(input logic [7:0] t);
		case (t)
			TOK_STAR: return OP_STAR;
			TOK_DOT:  return OP_CAT;
			TOK_BAR:  return OP_ALT;
			default:  return OP_LIT;
		endcase
	endfunction

	task automatic add_node(input bit final_mark, output int id);
		id = node_count;
		n_final[id]  = final_mark;
		n_symbol[id] = '0;
		n_sym_v[id]  = 1'b0;
		n_sym_to[id] = 0;
		n_epa_v[id]  = 1'b0;
		n_epa_to[id] = 0;
		n_epb_v[id]  = 1'b0;
		n_epb_to[id] = 0;
		node_count++;
	endtask

	// A node holds two epsilon links at most; a third one is lost.
	task automatic add_eps(input int from, input int to);
		if (!n_epa_v[from]) begin
			n_epa_v[from]  = 1'b1;
			n_epa_to[from] = to;
		end else if (!n_epb_v[from]) begin
			n_epb_v[from]  = 1'b1;
			n_epb_to[from] = to;
		end else begin
			lost_link = 1'b1;
		end
	endtask

	task automatic push_token(input logic [7:0] tok, output status_t code);
		op_t op;
		int  need, s, e, hs, he, ls, le;
		op   = token_op(tok);
		need = (op == OP_CAT || op == OP_ALT) ? 2 : (op == OP_STAR ? 1 : 0);
		code = STAT_OK;
		if (depth < need) begin
			code = STAT_UNDERFLOW;
		end else if (op == OP_LIT && depth >= STACK_DEPTH) begin
			code = STAT_STACK_FULL;
		end else if (op != OP_CAT && node_count + 2 > MAX_NODES) begin
			code = STAT_TABLE_FULL;
		end else begin
			lost_link = 1'b0;
			if (depth > 0) begin
				hs = stk_start[depth - 1];
				he = stk_end[depth - 1];
			end
			if (depth > 1) begin
				ls = stk_start[depth - 2];
				le = stk_end[depth - 2];
			end
			case (op)
				OP_LIT: begin
					add_node(1'b0, s);
					add_node(1'b1, e);
					n_sym_v[s]  = 1'b1;
					n_sym_to[s] = e;
					n_symbol[e] = tok;
					stk_start[depth] = s;
					stk_end[depth]   = e;
					depth++;
				end
				OP_STAR: begin
					add_node(1'b0, s);
					add_node(1'b1, e);
					add_eps(s, hs);
					add_eps(s, e);
					add_eps(he, e);
					add_eps(he, hs);
					n_final[he] = 1'b0;
					stk_start[depth - 1] = s;
					stk_end[depth - 1]   = e;
				end
				OP_CAT: begin
					add_eps(le, hs);
					n_final[le] = 1'b0;
					depth--;
					stk_start[depth - 1] = ls;
					stk_end[depth - 1]   = he;
				end
				default: begin
					add_node(1'b0, s);
					add_eps(s, ls);
					add_eps(s, hs);
					add_node(1'b1, e);
					add_eps(le, e);
					add_eps(he, e);
					n_final[le] = 1'b0;
					n_final[he] = 1'b0;
					depth--;
					stk_start[depth - 1] = s;
					stk_end[depth - 1]   = e;
				end
			endcase
			if (lost_link)
				code = STAT_DROPPED;
		end
	endtask

	task automatic build_step(input logic [1:0] m, input logic [7:0] tok,
			input logic [7:0] idx, output nfa_result_t r);
		status_t code;
		r = '0;
		case (m)
			MODE_PUSH: begin
				push_token(tok, code);
				r.code = code;
			end
			MODE_READ: begin
				if (idx >= node_count) begin
					r.code = STAT_BAD_INDEX;
				end else begin
					r.symbol     = n_symbol[idx];
					r.sym_v      = n_sym_v[idx];
					r.sym_to     = n_sym_v[idx] ? 8'(n_sym_to[idx]) : 8'd0;
					r.epa_v      = n_epa_v[idx];
					r.epa_to     = n_epa_v[idx] ? 8'(n_epa_to[idx]) : 8'd0;
					r.epb_v      = n_epb_v[idx];
					r.epb_to     = n_epb_v[idx] ? 8'(n_epb_to[idx]) : 8'd0;
					r.final_mark = n_final[idx];
				end
			end
			MODE_CLEAR: begin
				node_count = 0;
				depth      = 0;
			end
			default: ;
		endcase
		if (depth > 0) begin
			r.top_start = 8'(stk_start[depth - 1]);
			r.top_end   = 8'(stk_end[depth - 1]);
		end
		r.level = 7'(depth);
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		nfa_result_t want, fresh;
		if (!arst_n) begin
			node_count = 0;
			depth      = 0;
			due_results.delete();
			pending    = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					$display("%0t: result with no request waiting, status %0d", $time, status);
					errors++;
				end else begin
					want = due_results.pop_front();
					pending--;
					compared++;
					compare_field("status", want.code, status);
					compare_field("frag_start", want.top_start, frag_start);
					compare_field("frag_end", want.top_end, frag_end);
					compare_field("stack_level", want.level, stack_level);
					compare_field("node_symbol", want.symbol, node_symbol);
					compare_field("sym_link_valid", want.sym_v, sym_link_valid);
					compare_field("sym_link", want.sym_to, sym_link);
					compare_field("eps_a_valid", want.epa_v, eps_a_valid);
					compare_field("eps_a", want.epa_to, eps_a);
					compare_field("eps_b_valid", want.epb_v, eps_b_valid);
					compare_field("eps_b", want.epb_to, eps_b);
					compare_field("node_accepting", want.final_mark, node_accepting);
				end
			end
			if (in_valid && !in_stall) begin
				build_step(mode, token, node_index, fresh);
				due_results.push_back(fresh);
				pending++;
			end
		end
	end

endmodule

@@ tb/tb_postfix_regex_nfa_builder.sv @@
// Stimulus, handshake pacing and verdict for the postfix NFA builder testbench.
`timescale 1ns / 1ps

module tb_postfix_regex_nfa_builder
	import prnb_pkg::*;
();

	localparam int MAX_NODES   = 256;
	localparam int STACK_DEPTH = 64;
	localparam int ITEMS       = 2000;
	localparam int QUIET_LIMIT = 4000;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic       in_stall;
	logic [1:0] mode       = MODE_PUSH;
	logic [7:0] token      = '0;
	logic [7:0] node_index = '0;
	logic       out_valid;
	logic       out_stall  = 1'b0;
	logic [2:0] status;
	logic [7:0] frag_start;
	logic [7:0] frag_end;
	logic [6:0] stack_level;
	logic [7:0] node_symbol;
	logic       sym_link_valid;
	logic [7:0] sym_link;
	logic       eps_a_valid;
	logic [7:0] eps_a;
	logic       eps_b_valid;
	logic [7:0] eps_b;
	logic       node_accepting;

	int errors, pending, compared;

	// Pacing and a rough shadow of the builder, used to steer stimulus and count rejects.
	int send_idle = 28;
	int recv_idle = 76;
	int frag_depth, node_fill;
	int requests, underflows, stack_fulls, table_fulls, bad_reads;
	int quiet;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	postfix_regex_nfa_builder #(
		.MAX_NODES  (MAX_NODES),
		.STACK_DEPTH(STACK_DEPTH)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.token         (token),
		.node_index    (node_index),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.frag_start    (frag_start),
		.frag_end      (frag_end),
		.stack_level   (stack_level),
		.node_symbol   (node_symbol),
		.sym_link_valid(sym_link_valid),
		.sym_link      (sym_link),
		.eps_a_valid   (eps_a_valid),
		.eps_a         (eps_a),
		.eps_b_valid   (eps_b_valid),
		.eps_b         (eps_b),
		.node_accepting(node_accepting)
	);

	postfix_regex_nfa_checker #(
		.MAX_NODES  (MAX_NODES),
		.STACK_DEPTH(STACK_DEPTH)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.token         (token),
		.node_index    (node_index),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.frag_start    (frag_start),
		.frag_end      (frag_end),
		.stack_level   (stack_level),
		.node_symbol   (node_symbol),
		.sym_link_valid(sym_link_valid),
		.sym_link      (sym_link),
		.eps_a_valid   (eps_a_valid),
		.eps_a         (eps_a),
		.eps_b_valid   (eps_b_valid),
		.eps_b         (eps_b),
		.node_accepting(node_accepting),
		.errors        (errors),
		.pending       (pending),
		.compared      (compared)
	);

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no request or result moved for %0d cycles",
				$time, QUIET_LIMIT);
			$display("tb_postfix_regex_nfa_builder failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic track(input logic [1:0] m, input logic [7:0] t, input logic [7:0] idx);
		int need;
		need = (t == TOK_DOT || t == TOK_BAR) ? 2 : (t == TOK_STAR ? 1 : 0);
		if (m != MODE_NONE)
			requests++;
		case (m)
			MODE_CLEAR: begin
				frag_depth = 0;
				node_fill  = 0;
			end
			MODE_READ: begin
				if (idx >= node_fill)
					bad_reads++;
			end
			MODE_PUSH: begin
				if (frag_depth < need) begin
					underflows++;
				end else if (need == 0 && frag_depth >= STACK_DEPTH) begin
					stack_fulls++;
				end else if (t != TOK_DOT && node_fill + 2 > MAX_NODES) begin
					table_fulls++;
				end else begin
					if (t != TOK_DOT)
						node_fill += 2;
					if (need == 0)
						frag_depth++;
					else if (need == 2)
						frag_depth--;
				end
			end
			default: ;
		endcase
	endtask

	task automatic send(input logic [1:0] m, input logic [7:0] t, input logic [7:0] idx);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= m;
		token      <= t;
		node_index <= idx;
		do @(posedge clk); while (in_stall);
		track(m, t, idx);
	endtask

	// Holds the request side until every outstanding result has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_literal();
		logic [7:0] t;
		do t = 8'($urandom_range(255));
		while (t == TOK_STAR || t == TOK_DOT || t == TOK_BAR);
		return t;
	endfunction

	function automatic logic [7:0] pick_index();
		if (node_fill > 0 && $urandom_range(3) != 0)
			return 8'($urandom_range(node_fill - 1));
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] pick_operator();
		case ($urandom_range(2))
			0:       return TOK_STAR;
			1:       return TOK_DOT;
			default: return TOK_BAR;
		endcase
	endfunction

	// One step of a well-formed postfix expression, with an occasional node read.
	task automatic grow_expr();
		int r;
		r = $urandom_range(99);
		if (r < 12)
			send(MODE_READ, 8'($urandom_range(255)), pick_index());
		else if (frag_depth == 0 || (r < 50 && frag_depth < STACK_DEPTH))
			send(MODE_PUSH, rand_literal(), 8'($urandom_range(255)));
		else if (frag_depth == 1 || r < 65)
			send(MODE_PUSH, TOK_STAR, 8'($urandom_range(255)));
		else if (r < 82)
			send(MODE_PUSH, TOK_DOT, 8'($urandom_range(255)));
		else
			send(MODE_PUSH, TOK_BAR, 8'($urandom_range(255)));
	endtask

	task automatic deep_stack();
		send(MODE_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)));
		repeat (STACK_DEPTH + 3)
			send(MODE_PUSH, rand_literal(), 8'($urandom_range(255)));
		repeat (3)
			send(MODE_READ, 8'($urandom_range(255)), pick_index());
		while (frag_depth > 1)
			send(MODE_PUSH, pick_operator(), 8'($urandom_range(255)));
	endtask

	task automatic full_table();
		send(MODE_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)));
		while (node_fill < MAX_NODES)
			grow_expr();
		send(MODE_PUSH, rand_literal(), 8'($urandom_range(255)));
		send(MODE_PUSH, TOK_STAR, 8'($urandom_range(255)));
		send(MODE_PUSH, TOK_BAR, 8'($urandom_range(255)));
		send(MODE_PUSH, TOK_DOT, 8'($urandom_range(255)));
		send(MODE_READ, 8'($urandom_range(255)), 8'(MAX_NODES - 1));
		repeat (4)
			send(MODE_READ, 8'($urandom_range(255)), pick_index());
	endtask

	task automatic noise();
		logic [7:0] t;
		repeat ($urandom_range(10, 30)) begin
			t = ($urandom_range(2) == 0) ? pick_operator() : 8'($urandom_range(255));
			send(2'($urandom_range(3)), t, 8'($urandom_range(255)));
		end
	endtask

	task automatic expression();
		if ($urandom_range(4) != 0)
			send(MODE_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)));
		repeat ($urandom_range(4, 50))
			grow_expr();
	endtask

	task automatic directed();
		send(MODE_PUSH, TOK_STAR, 8'h00);
		send(MODE_PUSH, TOK_DOT, 8'hFF);
		send(MODE_READ, 8'h00, 8'h00);
		send(MODE_PUSH, 8'h00, 8'h00);
		send(MODE_PUSH, TOK_BAR, 8'h00);
		send(MODE_PUSH, TOK_DOT, 8'h00);
		send(MODE_PUSH, 8'hFF, 8'h00);
		send(MODE_PUSH, TOK_BAR, 8'h00);
		send(MODE_PUSH, TOK_STAR, 8'h00);
		send(MODE_PUSH, 8'h61, 8'h00);
		send(MODE_PUSH, TOK_DOT, 8'h00);
		for (int i = 0; i < 10; i++)
			send(MODE_READ, 8'hFF, 8'(i));
		send(MODE_NONE, 8'hFF, 8'hFF);
		send(MODE_READ, 8'h00, 8'hFF);
		send(MODE_CLEAR, 8'h00, 8'h00);
		send(MODE_READ, 8'h00, 8'h00);
	endtask

	initial begin
		int phase, session, r;
		phase = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		directed();
		for (session = 0; requests < ITEMS; session++) begin
			if (phase == 0 && requests >= ITEMS / 3) begin
				drain();
				phase     = 1;
				send_idle = 76;
				recv_idle = 28;
			end else if (phase == 1 && requests >= 2 * ITEMS / 3) begin
				drain();
				phase     = 2;
				send_idle = 0;
				recv_idle = 0;
			end
			r = $urandom_range(99);
			if (session == 0 || (session > 2 && r >= 60 && r < 75))
				deep_stack();
			else if (session == 1 || (session > 2 && r >= 75 && r < 88))
				full_table();
			else if (session == 2 || (session > 2 && r >= 88))
				noise();
			else
				expression();
		end
		drain();
		repeat (20) @(posedge clk);
		$display("%0d requests (expressions, deep stacks, full tables, noise), %0d checked.",
			requests, compared);
		$display("Rejected: %0d underflow, %0d stack full, %0d table full, %0d bad index.",
			underflows, stack_fulls, table_fulls, bad_reads);
		if (errors == 0)
			$display("tb_postfix_regex_nfa_builder passed");
		else
			$display("tb_postfix_regex_nfa_builder failed");
		$finish;
	end

endmodule

@@ files.f @@
design/prnb_pkg.sv
design/prnb_link_insert.sv
design/postfix_regex_nfa_builder.sv
tb/postfix_regex_nfa_checker.sv
tb/tb_postfix_regex_nfa_builder.sv
